// File: src/eost_pkg.sv
// ----------------------------------------------------------------------------
// Edge occupancy table package
// Shared constants, action and status codes for the edge occupancy table.
// ----------------------------------------------------------------------------
package eost_pkg;

  localparam int unsigned DefaultEntries = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned NodeW = 16;
  localparam int unsigned SpeedW = 26;
  localparam int unsigned TimeW = 40;
  localparam int unsigned LimitW = 27;
  localparam int unsigned LenW = 20;
  localparam int unsigned BaseW = 16;
  localparam logic [15:0] ThresholdReset = 16'd4;

  localparam logic [2:0] ActEnter = 3'd0;
  localparam logic [2:0] ActExit = 3'd1;
  localparam logic [2:0] ActSetLimit = 3'd2;
  localparam logic [2:0] ActClearLimit = 3'd3;
  localparam logic [2:0] ActQuery = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_clr;   // restart the table scan
    logic scan_step;  // look at one entry
    logic commit;     // apply the update and form the count
    logic eff_calc;   // register the effective speed
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic emit;       // show the result beat
  } eost_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic is_query;
  } eost_sts_t;

endpackage

// File: src/edge_occupancy_speed_table.sv
// Each item scans the whole table; a query also runs a bit-serial restoring divider.
// Throughput: one item at a time; busy is high from acceptance to the strobe.
// Results appear on result_valid_o for one cycle; the receiver cannot stall.
// Reset empties the table and sets the threshold to 4; no clearing pass.
// ----------------------------------------------------------------------------
// Edge occupancy and speed table
// Keyed table of road edges with vehicle counts, limit overrides and
// travel time queries.
// ----------------------------------------------------------------------------
module edge_occupancy_speed_table #(
  parameter int unsigned TableEntries = eost_pkg::DefaultEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i,
  input  logic [2:0]        action_i,
  input  logic [15:0]       from_node_i,
  input  logic [15:0]       to_node_i,
  input  logic signed [26:0] speed_limit_i,
  input  logic [15:0]       road_max_speed_i,
  input  logic [19:0]       road_length_i,
  input  logic [15:0]       vehicle_max_speed_i,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [15:0]       vehicle_count_o,
  output logic [25:0]       effective_speed_o,
  output logic [39:0]       travel_time_o
);
  import eost_pkg::*;

  eost_cmd_t   cmd;
  eost_sts_t   sts;
  logic [15:0] thr_q;

  // Threshold register; the port always takes a beat.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= ThresholdReset;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  eost_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  eost_datapath #(.Entries(TableEntries)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .threshold_i        (thr_q),
    .action_i           (action_i),
    .from_node_i        (from_node_i),
    .to_node_i          (to_node_i),
    .speed_limit_i      (speed_limit_i),
    .road_max_speed_i   (road_max_speed_i),
    .road_length_i      (road_length_i),
    .vehicle_max_speed_i(vehicle_max_speed_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .vehicle_count_o    (vehicle_count_o),
    .effective_speed_o  (effective_speed_o),
    .travel_time_o      (travel_time_o)
  );

endmodule

// File: src/eost_datapath.sv
// ----------------------------------------------------------------------------
// Edge occupancy table datapath
// Entry store, sequential key scan, update logic, speed scaling and a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eost_datapath #(
  parameter int unsigned Entries = eost_pkg::DefaultEntries
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  eost_pkg::eost_cmd_t   cmd_i,
  output eost_pkg::eost_sts_t   sts_o,
  input  logic [15:0]           threshold_i,
  input  logic [2:0]            action_i,
  input  logic [15:0]           from_node_i,
  input  logic [15:0]           to_node_i,
  input  logic signed [26:0]    speed_limit_i,
  input  logic [15:0]           road_max_speed_i,
  input  logic [19:0]           road_length_i,
  input  logic [15:0]           vehicle_max_speed_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [15:0]           vehicle_count_o,
  output logic [25:0]           effective_speed_o,
  output logic [39:0]           travel_time_o
);
  import eost_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned PtrW = $clog2(Entries + 1);
  localparam int unsigned DivW = 40;

  // Valid bits in flip-flops; payload in memories.
  logic [Entries-1:0] valid_q;
  logic [NodeW-1:0]   from_mem [Entries];
  logic [NodeW-1:0]   to_mem [Entries];
  logic [CountW-1:0]  cnt_mem [Entries];
  logic               ovr_v_mem [Entries];
  logic [SpeedW-1:0]  ovr_mem [Entries];

  // Captured item.
  logic [2:0]  act_q;
  logic [15:0] from_q, to_q, base_q, vms_q;
  logic [26:0] lim_q;
  logic [19:0] len_q;

  // Scan state.
  logic [PtrW-1:0] ptr_q;
  logic            hit_q, free_v_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_pend_q;
  logic [NodeW-1:0] rd_from_q, rd_to_q;
  logic            rd_valid_q;

  // Hit entry data, read after the scan.
  logic [CountW-1:0] e_cnt_q;
  logic              e_ovr_v_q;
  logic [SpeedW-1:0] e_ovr_q;

  logic [1:0]        status_q;
  logic [CountW-1:0] count_q;
  logic [SpeedW-1:0] eff_q;
  logic              valid_o_q;

  logic [DivW-1:0]   quo_q, rem_q, dvd_q;
  logic [SpeedW-1:0] dvs_q;
  logic [5:0]        div_cnt_q;

  // Result registers.
  logic [1:0]  status_o_r;
  logic [15:0] count_o_r;
  logic [25:0] eff_o_r;
  logic [39:0] time_o_r;

  logic [IdxW-1:0] ptr_idx;
  assign ptr_idx = ptr_q[IdxW-1:0];

  // Read one entry key per cycle; compare it in the next cycle.
  always_ff @(posedge clk_i) begin
    rd_from_q <= from_mem[ptr_idx];
    rd_to_q   <= to_mem[ptr_idx];
    e_cnt_q   <= cnt_mem[hit_idx_q];
    e_ovr_v_q <= ovr_v_mem[hit_idx_q];
    e_ovr_q   <= ovr_mem[hit_idx_q];
  end

  logic scan_done;
  assign scan_done = !rd_pend_q && (ptr_q == PtrW'(Entries));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      free_v_q   <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      free_v_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (rd_pend_q) begin
        if (rd_valid_q && rd_from_q == from_q && rd_to_q == to_q && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_idx_q;
        end
        if (!rd_valid_q && !free_v_q) begin
          free_v_q   <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
      end
      if (ptr_q != PtrW'(Entries)) begin
        rd_pend_q  <= 1'b1;
        rd_idx_q   <= ptr_idx;
        rd_valid_q <= valid_q[ptr_idx];
        ptr_q      <= ptr_q + 1'b1;
      end else begin
        rd_pend_q <= 1'b0;
      end
    end
  end

  // Capture the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      from_q <= from_node_i;
      to_q   <= to_node_i;
      lim_q  <= speed_limit_i;
      base_q <= road_max_speed_i;
      len_q  <= road_length_i;
      vms_q  <= vehicle_max_speed_i;
    end
  end

  // Update logic, evaluated in the commit cycle.
  logic [CountW-1:0] cur_cnt, new_cnt;
  logic              cur_ovr_v, new_ovr_v, wr_en, new_valid, alloc;
  logic [SpeedW-1:0] cur_ovr, new_ovr;
  logic [IdxW-1:0]   wr_idx;
  logic [1:0]        new_status;
  logic [CountW-1:0] out_cnt;

  always_comb begin
    alloc      = 1'b0;
    wr_en      = 1'b0;
    new_valid  = 1'b1;
    new_status = StOk;
    out_cnt    = '0;
    wr_idx     = hit_q ? hit_idx_q : free_idx_q;
    cur_cnt    = hit_q ? e_cnt_q : '0;
    cur_ovr_v  = hit_q ? e_ovr_v_q : 1'b0;
    cur_ovr    = hit_q ? e_ovr_q : '0;
    new_cnt    = cur_cnt;
    new_ovr_v  = cur_ovr_v;
    new_ovr    = cur_ovr;
    case (act_q)
      ActEnter, ActSetLimit: begin
        if (!hit_q && !free_v_q) begin
          new_status = StFull;
        end else begin
          alloc = !hit_q;
          wr_en = 1'b1;
          if (act_q == ActEnter) begin
            if (cur_cnt != '1) new_cnt = cur_cnt + 1'b1;
          end else begin
            new_ovr_v = 1'b1;
            new_ovr   = lim_q[26] ? '0 : lim_q[SpeedW-1:0];
          end
          out_cnt = new_cnt;
        end
      end
      ActExit, ActClearLimit: begin
        if (!hit_q) begin
          new_status = StNotFound;
        end else begin
          wr_en = 1'b1;
          if (act_q == ActExit) begin
            if (cur_cnt != '0) new_cnt = cur_cnt - 1'b1;
          end else begin
            new_ovr_v = 1'b0;
            new_ovr   = '0;
          end
          out_cnt   = new_cnt;
          new_valid = (new_cnt != '0) || new_ovr_v;
        end
      end
      ActQuery: out_cnt = cur_cnt;
      default: out_cnt = '0;
    endcase
  end

  // Entry writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      cnt_mem[wr_idx]   <= new_cnt;
      ovr_v_mem[wr_idx] <= new_ovr_v;
      ovr_mem[wr_idx]   <= new_ovr;
      if (alloc) begin
        from_mem[wr_idx] <= from_q;
        to_mem[wr_idx]   <= to_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit && wr_en) begin
      valid_q[wr_idx] <= new_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= new_status;
      count_q  <= out_cnt;
    end
  end

  // Effective speed: limit scaled by the congestion band.
  logic [SpeedW-1:0] base_fx, limit, eff_raw, eff_cl;
  logic [SpeedW+1:0] lim3;
  logic [16:0]       thr2;
  always_comb begin
    base_fx = {base_q, 10'd0};
    limit   = (cur_ovr_v && cur_ovr < base_fx) ? cur_ovr : base_fx;
    lim3    = {2'b00, limit} + {1'b0, limit, 1'b0};
    thr2    = {threshold_i, 1'b0};
    if (count_q <= 16'd1) eff_raw = limit;
    else if (count_q < threshold_i) eff_raw = lim3[SpeedW+1:2];
    else if ({1'b0, count_q} <= thr2) eff_raw = {1'b0, limit[SpeedW-1:1]};
    else eff_raw = {2'b00, limit[SpeedW-1:2]};
    eff_cl = (eff_raw == '0) ? SpeedW'(1) : eff_raw;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eff_calc) eff_q <= eff_cl;
  end

  // Restoring divider, one quotient bit per cycle.
  logic [SpeedW-1:0] vfx, dvs_d;
  logic [DivW:0]     rem_sh, rem_sub;
  assign vfx   = {(vms_q == '0) ? 16'd1 : vms_q, 10'd0};
  assign dvs_d = (eff_q < vfx) ? eff_q : vfx;
  assign rem_sh  = {rem_q, dvd_q[DivW-1]};
  assign rem_sub = rem_sh - {15'd0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= 6'(DivW);
    end else if (cmd_i.div_step && div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvs_q <= dvs_d;
      dvd_q <= {len_q, 20'd0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step && div_cnt_q != '0) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      if (!rem_sub[DivW]) begin
        rem_q <= rem_sub[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o_q <= 1'b0;
    else valid_o_q <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o_r <= status_q;
      count_o_r  <= count_q;
      eff_o_r    <= (act_q == ActQuery) ? eff_q : '0;
      time_o_r   <= (act_q == ActQuery) ? quo_q : '0;
    end
  end

  assign result_valid_o    = valid_o_q;
  assign status_o          = status_o_r;
  assign vehicle_count_o   = count_o_r;
  assign effective_speed_o = eff_o_r;
  assign travel_time_o     = time_o_r;

  assign sts_o.scan_done = scan_done;
  assign sts_o.div_done  = (div_cnt_q == '0);
  assign sts_o.is_query  = (act_q == ActQuery);

  // The scan pointer never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ptr_q <= PtrW'(Entries))
    else $error("scan pointer out of range");
  // A hit found by the scan must point at a valid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && hit_q |-> valid_q[hit_idx_q])
    else $error("hit on invalid entry");
  // A free entry chosen for allocation must be empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !hit_q && free_v_q |-> !valid_q[free_idx_q])
    else $error("allocation on a used entry");

endmodule

// File: src/eost_ctrl.sv
// ----------------------------------------------------------------------------
// Edge occupancy table controller
// Sequences load, scan, commit, speed scaling and division for queries, and the result beat.
// ----------------------------------------------------------------------------
module eost_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output eost_pkg::eost_cmd_t cmd_o,
  input  eost_pkg::eost_sts_t sts_i
);
  import eost_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SCommit = 3'd3;
  localparam logic [2:0] SEff = 3'd4;
  localparam logic [2:0] SDivLd = 3'd5;
  localparam logic [2:0] SDiv = 3'd6;
  localparam logic [2:0] SEmit = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = SScan;
        end
      end
      SScan: begin
        if (sts_i.scan_done) state_d = SRead;
        else cmd_o.scan_step = 1'b1;
      end
      SRead: state_d = SCommit;
      SCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.is_query ? SEff : SEmit;
      end
      SEff: begin
        cmd_o.eff_calc = 1'b1;
        state_d        = SDivLd;
      end
      SDivLd: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDiv;
      end
      SDiv: begin
        if (sts_i.div_done) state_d = SEmit;
        else cmd_o.div_step = 1'b1;
      end
      SEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != SIdle);

  // Only one item is in flight: a start while busy is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == SScan)
    else $error("start not taken");
  // A result beat always returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !busy_o)
    else $error("emit did not end the item");
  // The divider runs only for queries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> sts_i.is_query)
    else $error("divider started for a non-query");

endmodule
